// ===== sv/sfch_pkg.sv =====
// Package for the serial port FIFO call handler.
// Field widths, stream packing widths, action and function codes, and fixed reply words.
// No dependencies.
`default_nettype none

package sfch_pkg;

    localparam int unsigned FifoDepthDef = 1024;

    localparam int unsigned ActionW = 2;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned WordW   = 16;

    // s_axis_tdata: func_code, arg_byte, bx_in, link_up -> 33 bits, padded to 40
    localparam int unsigned InDataW  = 40;
    // m_axis_tdata: ax, bx, tx_byte, tx_valid, rx_accepted, hangup, dtr -> 44 bits, padded to 48
    localparam int unsigned OutDataW = 48;

    typedef enum logic [ActionW-1:0] {
        ACT_HOST    = 2'd0,
        ACT_LINK_RX = 2'd1,
        ACT_LINK_TX = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    localparam logic [ByteW-1:0] FN_TX_WAIT    = 8'h00;
    localparam logic [ByteW-1:0] FN_TX_WAIT2   = 8'h01;
    localparam logic [ByteW-1:0] FN_RX_READ    = 8'h02;
    localparam logic [ByteW-1:0] FN_STATUS     = 8'h03;
    localparam logic [ByteW-1:0] FN_INIT       = 8'h04;
    localparam logic [ByteW-1:0] FN_DEINIT     = 8'h05;
    localparam logic [ByteW-1:0] FN_DTR        = 8'h06;
    localparam logic [ByteW-1:0] FN_PURGE_TX   = 8'h09;
    localparam logic [ByteW-1:0] FN_PURGE_RX   = 8'h0A;
    localparam logic [ByteW-1:0] FN_TX_NOWAIT  = 8'h0B;
    localparam logic [ByteW-1:0] FN_PEEK       = 8'h0C;
    localparam logic [ByteW-1:0] FN_FLOW       = 8'h0F;
    localparam logic [ByteW-1:0] FN_BREAK      = 8'h10;

    localparam logic [WordW-1:0] AX_STATUS_BASE = 16'h6C10;
    localparam logic [WordW-1:0] AX_DATA_BASE   = 16'h6C00;
    localparam logic [WordW-1:0] AX_RX_NONE     = 16'h8000;
    localparam logic [WordW-1:0] AX_RX_READY    = 16'h0100;
    localparam logic [WordW-1:0] AX_CARRIER     = 16'h0080;
    localparam logic [WordW-1:0] AX_PEEK_NONE   = 16'hFFFF;
    localparam logic [WordW-1:0] AX_INIT_SIG    = 16'h1954;
    localparam logic [WordW-1:0] BX_INIT_INFO   = 16'h051B;

endpackage

`default_nettype wire

// ===== sv/serial_port_fifo_call_handler.sv =====
// Top level of the serial port FIFO call handler: input register, call decode,
// receive/transmit ring buffers and result register. Depends on sfch_pkg.
//
// Usage:
//   Input channel s_axis_*: one beat per host call (tuser = 0) or link event
//   (tuser = 1 link byte into receive ring, tuser = 2 link takes a transmit byte).
//   Output channel m_axis_*: exactly one result beat per input beat, in order.
//   Pipeline: a beat accepted into the input register is processed there and
//   its result goes to the result register. Throughput is one beat per cycle
//   while the receiver takes results; the ring buffer read port sets this: each
//   ring is read every cycle at the tail pointer the processing stage will see
//   next, with a write bypass. Both rings hold FIFO_DEPTH-1 bytes.
//   Reset (synchronous, active low): pointers zero so both rings are empty,
//   DTR high, pipeline empty. Ring storage is not cleared and no clearing
//   pass is needed; the block takes beats right after reset.
//   Receiver stall: the result register holds its beat; one more beat may sit
//   in the input register, after which s_axis_tready drops until m_axis_tready
//   returns.
`default_nettype none

module serial_port_fifo_call_handler #(
    parameter int unsigned FIFO_DEPTH = sfch_pkg::FifoDepthDef
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] func_code, [15:8] arg_byte, [31:16] bx_in, [32] link_up, rest zero
    input  wire logic [sfch_pkg::InDataW-1:0]  s_axis_tdata,
    // [1:0] action
    input  wire logic [sfch_pkg::ActionW-1:0]  s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [15:0] ax_out, [31:16] bx_out, [39:32] tx_byte, [40] tx_valid,
    // [41] rx_accepted, [42] hangup_request, [43] dtr_level, rest zero
    output logic [sfch_pkg::OutDataW-1:0]      m_axis_tdata
);
    import sfch_pkg::*;

    localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);

    function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
        ring_next = (p == PtrLast) ? '0 : p + 1'b1;
    endfunction

    // input register
    logic              r_in_valid;
    t_action           r_in_action;
    logic [ByteW-1:0]  r_in_func;
    logic [ByteW-1:0]  r_in_arg;
    logic [WordW-1:0]  r_in_bx;
    logic              r_in_link;

    // port state; flow-control and port-active flags affect no result and are not kept
    logic [PtrW-1:0]   r_rx_head, r_rx_tail, r_tx_head, r_tx_tail;
    logic [PtrW-1:0]   n_rx_head, n_rx_tail, n_tx_head, n_tx_tail;
    logic              r_dtr, n_dtr;

    // ring storage, read data registered
    logic [ByteW-1:0]  rx_mem [FIFO_DEPTH];
    logic [ByteW-1:0]  tx_mem [FIFO_DEPTH];
    logic [ByteW-1:0]  r_rx_q, r_tx_q;
    logic              rx_we, tx_we;

    // result register
    logic              r_out_valid;
    logic [OutDataW-1:0] r_out_data;

    logic              fire;
    logic              rx_empty, tx_empty, rx_full, tx_full;
    logic [PtrW-1:0]   st_rx_head, st_rx_tail, st_tx_head, st_tx_tail;
    logic              st_dtr;
    logic [WordW-1:0]  res_ax, res_bx;
    logic [ByteW-1:0]  res_txb;
    logic              res_txv, res_rxa, res_hang;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign rx_empty = (r_rx_head == r_rx_tail);
    assign tx_empty = (r_tx_head == r_tx_tail);
    assign rx_full  = (ring_next(r_rx_head) == r_rx_tail);
    assign tx_full  = (ring_next(r_tx_head) == r_tx_tail);

    always_comb begin
        st_rx_head = r_rx_head;
        st_rx_tail = r_rx_tail;
        st_tx_head = r_tx_head;
        st_tx_tail = r_tx_tail;
        st_dtr     = r_dtr;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        res_ax     = {r_in_func, r_in_arg};
        res_bx     = r_in_bx;
        res_txb    = '0;
        res_txv    = 1'b0;
        res_rxa    = 1'b0;
        res_hang   = 1'b0;
        case (r_in_action)
            ACT_HOST: begin
                case (r_in_func)
                    FN_TX_WAIT, FN_TX_WAIT2: begin
                        if (!tx_full) begin
                            tx_we      = 1'b1;
                            st_tx_head = ring_next(r_tx_head);
                        end
                        res_ax = AX_STATUS_BASE | (rx_empty ? '0 : AX_RX_READY);
                    end
                    FN_RX_READ: begin
                        if (rx_empty) begin
                            res_ax = AX_RX_NONE;
                        end else begin
                            res_ax     = AX_DATA_BASE | {{(WordW-ByteW){1'b0}}, r_rx_q};
                            st_rx_tail = ring_next(r_rx_tail);
                        end
                    end
                    FN_STATUS: begin
                        res_ax = AX_STATUS_BASE | (rx_empty ? '0 : AX_RX_READY)
                               | (r_in_link ? AX_CARRIER : '0);
                    end
                    FN_INIT: begin
                        st_dtr     = 1'b1;
                        st_rx_head = '0;
                        st_rx_tail = '0;
                        st_tx_head = '0;
                        st_tx_tail = '0;
                        res_ax     = AX_INIT_SIG;
                        res_bx     = BX_INIT_INFO;
                    end
                    FN_DTR: begin
                        st_dtr   = (r_in_arg != '0);
                        res_hang = (r_in_arg == '0) && r_in_link;
                    end
                    FN_PURGE_TX: begin
                        st_tx_head = '0;
                        st_tx_tail = '0;
                    end
                    FN_PURGE_RX: begin
                        st_rx_head = '0;
                        st_rx_tail = '0;
                    end
                    FN_TX_NOWAIT: begin
                        if (!tx_full) begin
                            tx_we      = 1'b1;
                            st_tx_head = ring_next(r_tx_head);
                        end
                        res_ax = {{(WordW-1){1'b0}}, !tx_full};
                    end
                    FN_PEEK: begin
                        res_ax = rx_empty ? AX_PEEK_NONE
                               : (AX_DATA_BASE | {{(WordW-ByteW){1'b0}}, r_rx_q});
                    end
                    FN_BREAK: begin
                        res_ax = '0;
                    end
                    // deinit, flow flags and unknown calls echo AX
                    default: ;
                endcase
            end
            ACT_LINK_RX: begin
                res_ax  = '0;
                res_bx  = '0;
                res_rxa = !rx_full;
                if (!rx_full) begin
                    rx_we      = 1'b1;
                    st_rx_head = ring_next(r_rx_head);
                end
            end
            ACT_LINK_TX: begin
                res_ax = '0;
                res_bx = '0;
                if (!tx_empty) begin
                    res_txb    = r_tx_q;
                    res_txv    = 1'b1;
                    st_tx_tail = ring_next(r_tx_tail);
                end
            end
            default: begin
                res_ax = '0;
                res_bx = '0;
            end
        endcase

        n_rx_head = fire ? st_rx_head : r_rx_head;
        n_rx_tail = fire ? st_rx_tail : r_rx_tail;
        n_tx_head = fire ? st_tx_head : r_tx_head;
        n_tx_tail = fire ? st_tx_tail : r_tx_tail;
        n_dtr     = fire ? st_dtr     : r_dtr;
    end

    // Rings are read every cycle at the tail the next beat will see; a write to
    // that same slot in this cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (fire && rx_we) begin
            rx_mem[r_rx_head] <= r_in_arg;
        end
        if (fire && rx_we && (r_rx_head == n_rx_tail)) begin
            r_rx_q <= r_in_arg;
        end else begin
            r_rx_q <= rx_mem[n_rx_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && tx_we) begin
            tx_mem[r_tx_head] <= r_in_arg;
        end
        if (fire && tx_we && (r_tx_head == n_tx_tail)) begin
            r_tx_q <= r_in_arg;
        end else begin
            r_tx_q <= tx_mem[n_tx_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_dtr       <= 1'b1;
        end else begin
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_dtr     <= n_dtr;
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= t_action'(s_axis_tuser);
            r_in_func   <= s_axis_tdata[7:0];
            r_in_arg    <= s_axis_tdata[15:8];
            r_in_bx     <= s_axis_tdata[31:16];
            r_in_link   <= s_axis_tdata[32];
        end
        if (fire) begin
            r_out_data <= {{(OutDataW-44){1'b0}}, st_dtr, res_hang, res_rxa, res_txv,
                           res_txb, res_bx, res_ax};
        end
    end

endmodule

`default_nettype wire

// ===== sv/sfch_checker.sv =====
// Port-level checker for the serial port FIFO call handler, with its bind.
// Depends on sfch_pkg and the top level serial_port_fifo_call_handler.
`default_nettype none

module sfch_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [sfch_pkg::OutDataW-1:0] m_axis_tdata
);
    import sfch_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // at most one of transmit byte, receive accept, hangup per beat
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[42:40]))
        else $error("more than one link event in a result beat");

    // beats with tx_valid or rx_accepted carry zero AX/BX; no byte without tx_valid
    a_link_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[40] || m_axis_tdata[41])
        |-> m_axis_tdata[31:0] == '0)
        else $error("link beat with nonzero AX/BX");

    a_txbyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[40] |-> m_axis_tdata[39:32] == '0)
        else $error("transmit byte without tx_valid");

    // hangup only with DTR low
    a_hang_dtr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[42] |-> !m_axis_tdata[43])
        else $error("hangup with DTR high");

endmodule

bind serial_port_fifo_call_handler sfch_checker u_sfch_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
